// ===== sv/ped_pkg.sv =====
// ----------------------------------------------------------------------------
// ped_pkg: shared types and constants of the percent escape decoder
// Holds the decode phase encoding, status codes, the escape character and
// the hex digit conversion used by the decode core.
// ----------------------------------------------------------------------------
`default_nettype none

package ped_pkg;

  localparam logic [7:0] EscChar = 8'h25;

  // Status codes carried on the result stream.
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StTrunc   = 2'd2;

  typedef enum logic [3:0] {
    PH_PASS = 4'b0001,
    PH_PCT  = 4'b0010,
    PH_DIG  = 4'b0100,
    PH_DROP = 4'b1000
  } phase_e;

  // One decoded result as seen by the output register.
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Returns {valid, nibble}; the nibble is zero for a non-hex character.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      // Letters A-F and a-f have low nibbles 1..6, so adding 9 gives 10..15.
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/percent_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// percent_escape_decoder: streaming percent escape decoder
// Passes plain bytes through, turns '%' plus two hex digits into one byte and
// reports truncated or invalid escapes, dropping the rest of a failed string.
//
//   Channel  Dir  tdata            tuser        tlast
//   s_axis   in   [7:0] in_byte    -            in_last
//   m_axis   out  [7:0] out_byte   [1:0] status out_last
//
// One byte is accepted per cycle while the result register has room or the
// held byte makes no result; a result passes the input register, then the
// result register, before it is presented.
// The decode core updates its phase whenever a held byte is taken.
// Reset clears the phase to pass-through and empties both registers.
// A stalled result register holds back only bytes that produce a result.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_escape_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]      m_axis_tuser,   // [1:0] status
  output logic            m_axis_tlast
);
  import ped_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       take;
  logic       out_space;
  result_t    res;

  // A held byte moves on when it makes no result or the result register
  // has room for it.
  assign take = held_valid && (!res.emit || out_space);

  ped_in_stage u_in (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .take_i   (take),
    .valid_o  (held_valid),
    .byte_o   (held_byte),
    .last_o   (held_last)
  );

  ped_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (held_byte),
    .last_i (held_last),
    .take_i (take),
    .res_o  (res)
  );

  ped_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (res),
    .load_i   (take && res.emit),
    .space_o  (out_space),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .data_o   (m_axis_tdata),
    .status_o (m_axis_tuser),
    .last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/ped_in_stage.sv =====
// ----------------------------------------------------------------------------
// ped_in_stage: input register of the percent escape decoder
// Captures one input transaction and holds it until the decode core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       tvalid_i,
  output logic            tready_o,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  // A new transaction may enter in the same cycle the held one is taken.
  assign tready_o = !valid_q || take_i;
  assign load     = tvalid_i && tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== sv/ped_core.sv =====
// ----------------------------------------------------------------------------
// ped_core: decode phase tracking of the percent escape decoder
// Works out the result for the held byte from the current phase and steps
// the phase when the byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     byte_i,
  input  wire logic           last_i,
  input  wire logic           take_i,
  output ped_pkg::result_t    res_o
);
  import ped_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic [4:0] hi, lo;
  result_t    res;

  assign hi = hex_nibble(first_q);
  assign lo = hex_nibble(byte_i);

  always_comb begin
    phase_d    = phase_q;
    first_d    = first_q;
    res.emit   = 1'b0;
    res.data   = 8'd0;
    res.status = StOk;
    res.last   = 1'b1;
    case (phase_q)
      PH_PASS: begin
        if (byte_i != EscChar) begin
          res.emit = 1'b1;
          res.data = byte_i;
          res.last = last_i;
        end else if (last_i) begin
          res.emit   = 1'b1;
          res.status = StTrunc;
        end else begin
          phase_d = PH_PCT;
        end
      end
      PH_PCT: begin
        first_d = byte_i;
        if (last_i) begin
          res.emit   = 1'b1;
          res.status = StTrunc;
          phase_d    = PH_PASS;
        end else begin
          phase_d = PH_DIG;
        end
      end
      PH_DIG: begin
        res.emit = 1'b1;
        if (hi[4] && lo[4]) begin
          res.data = {hi[3:0], lo[3:0]};
          res.last = last_i;
          phase_d  = PH_PASS;
        end else begin
          // An error closes the string; the rest of it is dropped.
          res.status = StInvalid;
          phase_d    = last_i ? PH_PASS : PH_DROP;
        end
      end
      PH_DROP: begin
        if (last_i) begin
          phase_d = PH_PASS;
        end
      end
      default: begin
        phase_d = PH_PASS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PASS;
      first_q <= 8'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ===== sv/ped_out_stage.sv =====
// ----------------------------------------------------------------------------
// ped_out_stage: result register of the percent escape decoder
// Holds one result transaction until the downstream side accepts it.
// ----------------------------------------------------------------------------
`default_nettype none

module ped_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ped_pkg::result_t res_i,
  input  wire logic             load_i,
  output logic                  space_o,
  input  wire logic             tready_i,
  output logic                  tvalid_o,
  output logic [7:0]            data_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);
  import ped_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic [1:0] status_q;
  logic       last_q;

  assign space_o = !valid_q || tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q   <= res_i.data;
      status_q <= res_i.status;
      last_q   <= res_i.last;
    end
  end

  assign tvalid_o = valid_q;
  assign data_o   = data_q;
  assign status_o = status_q;
  assign last_o   = last_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the percent escape decoder
// A short table of byte strings covers plain bytes, escapes in both letter
// cases, truncated and invalid escapes and dropping after an error. Random
// strings follow, mostly well-formed with some broken ones and noise. Every
// result is checked against a typed row or the bench-side decoder, and the
// sender and the receiver idle and stall in several phases.
// ----------------------------------------------------------------------------
module tb;
  import ped_pkg::*;

  localparam int RandItems   = 400;
  localparam int PhaseItems  = 100;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 10;
  localparam int IdleLimit   = 2000;
  localparam int DirRows     = 23;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } decoded_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
    logic       typed;
    decoded_t   res;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic [1:0] m_axis_tuser;           // [1:0] status
  logic       m_axis_tlast;

  // Bench-side decoder state.
  phase_e     dec_phase = PH_PASS;
  logic [7:0] dec_first = 8'h00;
  int         live_items = 0;

  decoded_t   decoded_q[$];
  int         mismatches = 0;
  int         results_seen = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  bit         hold_req = 1'b0;
  int         idle_cycles = 0;

  // Expected results are typed in only where they are obvious.
  dir_row_t dir_rows[DirRows] = '{
    '{8'h00,   1'b0, 1'b1, '{8'h00, StOk,      1'b0}},
    '{8'hFF,   1'b0, 1'b1, '{8'hFF, StOk,      1'b0}},
    '{EscChar, 1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h34,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h31,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{EscChar, 1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h66,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h46,   1'b1, 1'b0, '{8'h00, StOk,      1'b0}},
    '{EscChar, 1'b1, 1'b1, '{8'h00, StTrunc,   1'b1}},
    '{EscChar, 1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h7A,   1'b1, 1'b1, '{8'h00, StTrunc,   1'b1}},
    '{EscChar, 1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h47,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h31,   1'b0, 1'b1, '{8'h00, StInvalid, 1'b1}},
    '{8'h78,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{EscChar, 1'b1, 1'b0, '{8'h00, StOk,      1'b0}},
    '{EscChar, 1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h31,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h67,   1'b1, 1'b1, '{8'h00, StInvalid, 1'b1}},
    '{EscChar, 1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h30,   1'b0, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h30,   1'b1, 1'b0, '{8'h00, StOk,      1'b0}},
    '{8'h7F,   1'b1, 1'b1, '{8'h7F, StOk,      1'b1}}
  };

  percent_escape_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  // Advances the decoder by one byte and gives the result it causes, if any.
  function automatic void decode_byte(input logic [7:0] b, input logic l,
                                      output bit emits, output decoded_t r);
    emits = 1'b0;
    r = '{8'h00, StOk, 1'b0};
    if (dec_phase != PH_DROP) begin
      live_items++;
    end
    case (dec_phase)
      PH_PASS: begin
        if (b != EscChar) begin
          emits = 1'b1;
          r = '{b, StOk, l};
        end else if (l) begin
          emits = 1'b1;
          r = '{8'h00, StTrunc, 1'b1};
        end else begin
          dec_phase = PH_PCT;
        end
      end
      PH_PCT: begin
        dec_first = b;
        if (l) begin
          dec_phase = PH_PASS;
          emits = 1'b1;
          r = '{8'h00, StTrunc, 1'b1};
        end else begin
          dec_phase = PH_DIG;
        end
      end
      PH_DIG: begin
        emits = 1'b1;
        if (is_hex(dec_first) && is_hex(b)) begin
          dec_phase = PH_PASS;
          r = '{{hex_val(dec_first), hex_val(b)}, StOk, l};
        end else begin
          dec_phase = l ? PH_PASS : PH_DROP;
          r = '{8'h00, StInvalid, 1'b1};
        end
      end
      default: begin
        if (l) begin
          dec_phase = PH_PASS;
        end
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0: return 8'(8'h30 + $urandom_range(0, 9));
      1: return 8'(8'h41 + $urandom_range(0, 5));
      default: return 8'(8'h61 + $urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_nonhex();
    logic [7:0] c;
    c = 8'($urandom);
    while (is_hex(c)) begin
      c = 8'($urandom);
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    c = 8'($urandom);
    while (c == EscChar) begin
      c = 8'($urandom);
    end
    return c;
  endfunction

  // Appends one byte at the end of a string.
  function automatic void add_byte(ref logic [7:0] s[$], input logic [7:0] b);
    s = {s, b};
  endfunction

  // Mostly well-formed strings with random content, then broken ones and noise.
  function automatic void build_string(ref logic [7:0] s[$]);
    int mode;
    int ntok;
    s.delete();
    mode = $urandom_range(0, 99);
    ntok = $urandom_range(1, 6);
    if (mode < 85) begin
      for (int i = 0; i < ntok; i++) begin
        if ($urandom_range(0, 99) < 40) begin
          add_byte(s, EscChar);
          add_byte(s, rand_hex());
          add_byte(s, rand_hex());
        end else begin
          add_byte(s, rand_plain());
        end
      end
      if (mode >= 70) begin
        case ($urandom_range(0, 3))
          0: add_byte(s, EscChar);
          1: begin
            add_byte(s, EscChar);
            add_byte(s, 8'($urandom));
          end
          default: begin
            add_byte(s, EscChar);
            case ($urandom_range(0, 2))
              0: begin
                add_byte(s, rand_nonhex());
                add_byte(s, rand_hex());
              end
              1: begin
                add_byte(s, rand_hex());
                add_byte(s, rand_nonhex());
              end
              default: begin
                add_byte(s, rand_nonhex());
                add_byte(s, rand_nonhex());
              end
            endcase
            // Trailing bytes that the block has to drop.
            for (int i = $urandom_range(0, 3); i > 0; i--) begin
              add_byte(s, $urandom_range(0, 1) ? EscChar : 8'($urandom));
            end
          end
        endcase
      end
    end else begin
      for (int i = 0; i < ntok; i++) begin
        add_byte(s, $urandom_range(0, 99) < 30 ? EscChar : 8'($urandom));
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic drive_byte(input logic [7:0] b, input logic l, input logic typed,
                            input decoded_t typed_res);
    bit       emits;
    decoded_t r;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    decode_byte(b, l, emits, r);
    if (typed) begin
      decoded_q = {decoded_q, typed_res};
    end else if (emits) begin
      decoded_q = {decoded_q, r};
    end
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("result %0d: %s got 0x%0h, expected 0x%0h", results_seen, what, got, want);
    mismatches++;
  endtask

  initial begin
    logic [7:0] str[$];
    int         phase_idx;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      drive_byte(dir_rows[i].in_byte, dir_rows[i].in_last, dir_rows[i].typed,
                 dir_rows[i].res);
    end

    // The receiver holds off for a while so that the block fills and stalls.
    hold_req = 1'b1;
    while (live_items < DirRows + RandItems) begin
      phase_idx = ((live_items - DirRows) / PhaseItems) % 4;
      case (phase_idx)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 55;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 55;
        end
        default: begin
          src_idle_pct  = 8;
          snk_stall_pct = 8;
        end
      endcase
      build_string(str);
      foreach (str[i]) begin
        drive_byte(str[i], i == str.size() - 1, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        for (int i = 0; i < HoldCycles; i++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result, out_byte", m_axis_tdata, 0);
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          report_mismatch("out_byte", m_axis_tdata, want.data);
        end
        if (m_axis_tuser !== want.status) begin
          report_mismatch("status", m_axis_tuser, want.status);
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("out_last", m_axis_tlast, want.last);
        end
      end
      results_seen++;
    end
  end

  // Ends a run in which no transaction happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
